FILE: rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/pcr_pkg.sv
// Shared types, constants and helper functions of the coverage ratio judge.
`timescale 1ns / 1ps
package pcr_pkg;

  localparam int VAL_W      = 24;
  localparam int UNC_W      = 23;
  localparam int CUT_W      = 16;
  localparam int COUNT_W    = 17;
  localparam int SUM_W      = 40;
  localparam int ND_W       = COUNT_W + 1;
  localparam int Q_SHIFT    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = UNC_W;
  localparam int COV_W      = 2;

  // Shift-add multiplier geometry
  localparam int MUL_A_W   = SUM_W;
  localparam int MUL_B_W   = CUT_W + ND_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNCER_CUT        = 3'd0,
    CFG_CHARGE_CUT_SCALE = 3'd1,
    CFG_CHARGE_CUT_LIMIT = 3'd2,
    CFG_COUNT_CUT_SCALE  = 3'd3,
    CFG_COUNT_CUT_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [COV_W-1:0] {
    COV_OTHER      = 2'd0,
    COV_REF_COVERS = 2'd1,
    COV_TAR_COVERS = 2'd2
  } cov_e;

  typedef enum logic [1:0] {
    TEST_CHARGE_SCALE = 2'd0,
    TEST_CHARGE_LIMIT = 2'd1,
    TEST_COUNT_SCALE  = 2'd2,
    TEST_COUNT_LIMIT  = 2'd3
  } test_e;

  typedef enum logic [2:0] {
    S_RUN   = 3'd0,
    S_PREP  = 3'd1,
    S_LOAD  = 3'd2,
    S_MUL   = 3'd3,
    S_CHECK = 3'd4,
    S_DONE  = 3'd5
  } state_e;

  typedef struct packed {
    logic  accept;
    logic  prep;
    logic  load;
    logic  step;
    logic  check;
    logic  out_load;
    test_e test;
  } cmd_t;

  typedef struct packed {
    logic need_tests;
  } status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
    return (&cnt) ? cnt : cnt + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                               input logic [VAL_W-2:0] val);
    logic [SUM_W:0] s;
    s = {1'b0, sum} + (SUM_W+1)'(val);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

FILE: rtl/pcr_if.sv
// Valid/ready channel interfaces for cell words and coverage words.
`timescale 1ns / 1ps
interface pcr_in_if;
  import pcr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] ref_value;
  logic signed [VAL_W-1:0] tar_value;
  logic                    last;

  modport source (output valid, output ref_value, output tar_value, output last,
                  input ready);
  modport sink   (input valid, input ref_value, input tar_value, input last,
                  output ready);
endinterface

interface pcr_out_if;
  import pcr_pkg::*;
  logic             valid;
  logic             ready;
  logic [COV_W-1:0] coverage;

  modport source (output valid, output coverage, input ready);
  modport sink   (input valid, input coverage, output ready);
endinterface

FILE: rtl/projection_coverage_ratio_judge_unit.sv
// Top level of the projection coverage ratio judge.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        ref_value, tar_value (signed 24), last
//   out_ch   out  valid/ready        coverage (2)
//   cfg      in   cfg_we_i           cfg_idx_i (3), cfg_data_i (23)
//
// In the run state a non-last cell word is taken every cycle and folded into the
// counters. A last cell word then passes prep, load and done if the counts decide
// the code, or prep, then for each of the four cross-multiplied ratio tests load,
// multiply on the 34-bit bit-serial shift-add multiplier pair and check, then done.
// Reset is asynchronous, active low, and clears counters, config and state.
// A finished word waits in the output register; cell words are still taken.
`timescale 1ns / 1ps
module projection_coverage_ratio_judge_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pcr_in_if.sink                         in_ch,
  pcr_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pcr_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready, out_valid;

  pcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.last),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  pcr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ref_value_i (in_ch.ref_value),
    .tar_value_i (in_ch.tar_value),
    .cmd_i       (cmd),
    .status_o    (status),
    .coverage_o  (out_ch.coverage)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

FILE: rtl/pcr_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per step, MSB first.
`timescale 1ns / 1ps
module pcr_mul (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic [pcr_pkg::MUL_A_W-1:0] a_i,
  input  logic [pcr_pkg::MUL_B_W-1:0] b_i,
  output logic [pcr_pkg::PROD_W-1:0]  prod_o
);
  import pcr_pkg::*;

  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [MUL_A_W-1:0] a_q, a_d;
  logic [MUL_B_W-1:0] b_q, b_d;

  always_comb begin
    acc_d = acc_q;
    a_d   = a_q;
    b_d   = b_q;
    if (load_i) begin
      acc_d = '0;
      a_d   = a_i;
      b_d   = b_i;
    end else if (step_i) begin
      acc_d = {acc_q[PROD_W-2:0], 1'b0} + (b_q[MUL_B_W-1] ? PROD_W'(a_q) : '0);
      b_d   = {b_q[MUL_B_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign prod_o = acc_q;

endmodule

FILE: rtl/pcr_dp.sv
// Datapath: config registers, cell counters and sums, ratio tests, result register.
`timescale 1ns / 1ps
module pcr_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [pcr_pkg::VAL_W-1:0] ref_value_i,
  input  logic signed [pcr_pkg::VAL_W-1:0] tar_value_i,
  input  pcr_pkg::cmd_t                  cmd_i,
  output pcr_pkg::status_t               status_o,
  output logic [pcr_pkg::COV_W-1:0]      coverage_o
);
  import pcr_pkg::*;

  // Configuration
  logic [UNC_W-1:0] uncer_cut_q;
  logic [CUT_W-1:0] chg_scale_q, chg_limit_q, cnt_scale_q, cnt_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uncer_cut_q <= '0;
      chg_scale_q <= '0;
      chg_limit_q <= '0;
      cnt_scale_q <= '0;
      cnt_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UNCER_CUT:        uncer_cut_q <= cfg_data_i[UNC_W-1:0];
        CFG_CHARGE_CUT_SCALE: chg_scale_q <= cfg_data_i[CUT_W-1:0];
        CFG_CHARGE_CUT_LIMIT: chg_limit_q <= cfg_data_i[CUT_W-1:0];
        CFG_COUNT_CUT_SCALE:  cnt_scale_q <= cfg_data_i[CUT_W-1:0];
        CFG_COUNT_CUT_LIMIT:  cnt_limit_q <= cfg_data_i[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell classification
  logic signed [VAL_W:0] ref_ext, tar_ext, dead_lim;
  logic ref_live, tar_live, ref_dead, tar_dead;

  assign ref_ext  = {ref_value_i[VAL_W-1], ref_value_i};
  assign tar_ext  = {tar_value_i[VAL_W-1], tar_value_i};
  assign dead_lim = $signed(-{2'b00, uncer_cut_q});
  assign ref_live = !ref_value_i[VAL_W-1] && (ref_value_i != '0);
  assign tar_live = !tar_value_i[VAL_W-1] && (tar_value_i != '0);
  assign ref_dead = ref_ext < dead_lim;
  assign tar_dead = tar_ext < dead_lim;

  // Accumulators
  logic [COUNT_W-1:0] ref_lc_q, ref_dc_q, tar_lc_q, tar_dc_q, com_cnt_q;
  logic [SUM_W-1:0]   ref_sum_q, tar_sum_q, com_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lc_q  <= '0;
      ref_dc_q  <= '0;
      tar_lc_q  <= '0;
      tar_dc_q  <= '0;
      com_cnt_q <= '0;
      ref_sum_q <= '0;
      tar_sum_q <= '0;
      com_sum_q <= '0;
    end else if (cmd_i.out_load) begin
      ref_lc_q  <= '0;
      ref_dc_q  <= '0;
      tar_lc_q  <= '0;
      tar_dc_q  <= '0;
      com_cnt_q <= '0;
      ref_sum_q <= '0;
      tar_sum_q <= '0;
      com_sum_q <= '0;
    end else if (cmd_i.accept) begin
      if (ref_live) begin
        ref_lc_q  <= sat_inc(ref_lc_q);
        ref_sum_q <= sat_add(ref_sum_q, ref_value_i[VAL_W-2:0]);
      end else if (ref_dead) begin
        ref_dc_q <= sat_inc(ref_dc_q);
      end
      if (tar_live) begin
        tar_lc_q  <= sat_inc(tar_lc_q);
        tar_sum_q <= sat_add(tar_sum_q, tar_value_i[VAL_W-2:0]);
      end else if (tar_dead) begin
        tar_dc_q <= sat_inc(tar_dc_q);
      end
      if (ref_live && tar_live) begin
        com_cnt_q <= sat_inc(com_cnt_q);
        com_sum_q <= sat_add(com_sum_q, ref_value_i[VAL_W-2:0]);
      end
    end
  end

  // Early decision and pick of the smaller map
  logic               small_ref;
  logic [COUNT_W-1:0] sm_n, sm_d;
  logic [SUM_W-1:0]   sm_c;
  cov_e               early_code;
  logic               early_need;

  always_comb begin
    small_ref  = ref_lc_q < tar_lc_q;
    sm_n       = small_ref ? ref_lc_q  : tar_lc_q;
    sm_d       = small_ref ? ref_dc_q  : tar_dc_q;
    sm_c       = small_ref ? ref_sum_q : tar_sum_q;
    early_need = 1'b0;
    if (ref_lc_q != '0 && tar_lc_q != '0 && com_cnt_q == '0) begin
      early_code = COV_OTHER;
    end else if (com_cnt_q == ref_lc_q) begin
      early_code = COV_TAR_COVERS;
    end else if (com_cnt_q == tar_lc_q) begin
      early_code = COV_REF_COVERS;
    end else if (sm_n == '0 || sm_c == '0) begin
      early_code = COV_OTHER;
    end else begin
      early_code = small_ref ? COV_TAR_COVERS : COV_REF_COVERS;
      early_need = 1'b1;
    end
  end

  cov_e               code_q;
  logic               need_q, pass_q;
  logic [COUNT_W-1:0] n_q, nloss_q;
  logic [SUM_W-1:0]   c_q, closs_q;
  logic [ND_W-1:0]    nd_q;
  logic [COV_W-1:0]   coverage_q;

  // Two multiplier lanes: left and right side of one cross-multiplied test
  logic [MUL_A_W-1:0] la, ra;
  logic [MUL_B_W-1:0] lb, rb;
  logic [PROD_W-1:0]  lprod, rprod;

  always_comb begin
    la = closs_q;
    lb = MUL_B_W'(1) << Q_SHIFT;
    ra = c_q;
    rb = MUL_B_W'(chg_limit_q);
    case (cmd_i.test)
      TEST_CHARGE_SCALE: begin
        lb = MUL_B_W'({n_q, {Q_SHIFT{1'b0}}});
        rb = MUL_B_W'(chg_scale_q) * MUL_B_W'(nd_q);
      end
      TEST_CHARGE_LIMIT: ;
      TEST_COUNT_SCALE: begin
        la = MUL_A_W'(nloss_q);
        ra = MUL_A_W'(nd_q);
        rb = MUL_B_W'(cnt_scale_q);
      end
      TEST_COUNT_LIMIT: begin
        la = MUL_A_W'(nloss_q);
        ra = MUL_A_W'(n_q);
        rb = MUL_B_W'(cnt_limit_q);
      end
      default: ;
    endcase
  end

  pcr_mul u_mul_l (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .step_i (cmd_i.step),
    .a_i    (la),
    .b_i    (lb),
    .prod_o (lprod)
  );

  pcr_mul u_mul_r (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .step_i (cmd_i.step),
    .a_i    (ra),
    .b_i    (rb),
    .prod_o (rprod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      code_q  <= early_code;
      need_q  <= early_need;
      pass_q  <= 1'b1;
      n_q     <= sm_n;
      c_q     <= sm_c;
      nd_q    <= {1'b0, sm_n} + {1'b0, sm_d};
      closs_q <= (sm_c >= com_sum_q) ? sm_c - com_sum_q : '0;
      nloss_q <= (sm_n >= com_cnt_q) ? sm_n - com_cnt_q : '0;
    end else if (cmd_i.check) begin
      pass_q <= pass_q & (lprod < rprod);
    end
    if (cmd_i.out_load) begin
      coverage_q <= (need_q && !pass_q) ? COV_OTHER : code_q;
    end
  end

  assign status_o.need_tests = need_q;
  assign coverage_o          = coverage_q;

endmodule

FILE: rtl/pcr_ctrl.sv
// Controller: accepts cell words, sequences the ratio tests, owns the result valid.
`timescale 1ns / 1ps
module pcr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  logic             out_ready_i,
  input  pcr_pkg::status_t status_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output pcr_pkg::cmd_t    cmd_o
);
  import pcr_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  test_e             test_q, test_d;
  logic              out_valid_q, out_valid_d;
  cmd_t              cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      step_q      <= '0;
      test_q      <= TEST_CHARGE_SCALE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      test_q      <= test_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    test_d     = test_q;
    in_ready_o = 1'b0;
    cmd        = '0;
    case (state_q)
      S_RUN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          if (in_last_i) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        test_d   = TEST_CHARGE_SCALE;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        if (!status_i.need_tests) begin
          state_d = S_DONE;
        end else begin
          cmd.load = 1'b1;
          step_d   = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.step = 1'b1;
        step_d   = step_q + 1'b1;
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (test_q == TEST_COUNT_LIMIT) begin
          state_d = S_DONE;
        end else begin
          test_d  = test_e'(test_q + 2'd1);
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        // hold until the previous word has left the output register
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
    cmd.test = test_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: rtl/pcr_checker.sv
// Port-level assertion checker for the coverage ratio judge, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] coverage_i
);

  `PCR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PCR_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(coverage_i))
  `PCR_ASSERT_NXT(a_last_stalls, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i)
  `PCR_ASSERT_IMP(a_rise_after_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))
  `PCR_ASSERT_NXT(a_no_word_mid_map, clk_i, rst_ni, in_valid_i && in_ready_i && !in_last_i && !out_valid_i, !out_valid_i)

endmodule

bind projection_coverage_ratio_judge_unit pcr_checker u_pcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_last_i   (in_ch.last),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .coverage_i  (out_ch.coverage)
);
